/* hw/rtl/fpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants of the fixed-point alu
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS_DEFAULT = 8;
  localparam int WORD_W            = 32;

  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_GT       = 4'd4,
    FN_LT       = 4'd5,
    FN_GE       = 4'd6,
    FN_LE       = 4'd7,
    FN_EQ       = 4'd8,
    FN_NE       = 4'd9,
    FN_MIN      = 4'd10,
    FN_MAX      = 4'd11,
    FN_INC      = 4'd12,
    FN_DEC      = 4'd13,
    FN_TO_INT   = 4'd14,
    FN_FROM_INT = 4'd15
  } func_t;

  // result data that rides along the divider pipeline
  typedef struct packed {
    logic [WORD_W-1:0] value;   // result of every operation but divide and the comparisons
    logic              cmp;     // comparison outcome
    logic              is_div;  // take the quotient instead of value
    logic              dz;      // divide by zero
    logic              neg;     // quotient sign
  } side_t;

endpackage

/* hw/rtl/fpa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// two-stage front end: decode, simple ops, multiply, divide operand setup
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
  parameter int DW        = WORD_W + FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [3:0]               func,
  input  logic signed [WORD_W-1:0] operand_a,
  input  logic signed [WORD_W-1:0] operand_b,
  output logic                     out_valid,
  output side_t                    out_side,
  output logic [WORD_W-1:0]        out_dvsr,
  output logic [DW-1:0]            out_dvnd
);

  // stage a
  logic                       valid_a;
  logic                       is_mul_a;
  logic signed [2*WORD_W-1:0] prod_a;
  side_t                      side_a;
  logic [WORD_W-1:0]          dvsr_a;
  logic [DW-1:0]              dvnd_a;

  side_t             side_next;
  side_t             side_b_next;
  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;
  func_t             fn;

  always_comb begin
    fn        = func_t'(func);
    side_next = '0;
    mag_a     = operand_a[WORD_W-1] ? WORD_W'(-operand_a) : WORD_W'(operand_a);
    mag_b     = operand_b[WORD_W-1] ? WORD_W'(-operand_b) : WORD_W'(operand_b);
    case (fn)
      FN_ADD:      side_next.value = WORD_W'(operand_a + operand_b);
      FN_SUB:      side_next.value = WORD_W'(operand_a - operand_b);
      FN_MUL:      side_next.value = '0;
      FN_DIV: begin
        side_next.is_div = 1'b1;
        side_next.dz     = (operand_b == '0);
        side_next.neg    = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
      end
      FN_GT:       side_next.cmp = (operand_a > operand_b);
      FN_LT:       side_next.cmp = (operand_a < operand_b);
      FN_GE:       side_next.cmp = (operand_a >= operand_b);
      FN_LE:       side_next.cmp = (operand_a <= operand_b);
      FN_EQ:       side_next.cmp = (operand_a == operand_b);
      FN_NE:       side_next.cmp = (operand_a != operand_b);
      FN_MIN:      side_next.value = (operand_a < operand_b) ? operand_a : operand_b;
      FN_MAX:      side_next.value = (operand_a > operand_b) ? operand_a : operand_b;
      FN_INC:      side_next.value = WORD_W'(operand_a + 1);
      FN_DEC:      side_next.value = WORD_W'(operand_a - 1);
      FN_TO_INT:   side_next.value = WORD_W'(operand_a >>> FRAC_BITS);
      FN_FROM_INT: side_next.value = WORD_W'(operand_a << FRAC_BITS);
      default:     side_next.value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= in_valid;
    end
    is_mul_a <= (func_t'(func) == FN_MUL);
    prod_a   <= (2*WORD_W)'(operand_a) * (2*WORD_W)'(operand_b);
    side_a   <= side_next;
    dvsr_a   <= mag_b;
    dvnd_a   <= {mag_a, {FRAC_BITS{1'b0}}};
  end

  // stage b: scale the product
  always_comb begin
    side_b_next = side_a;
    if (is_mul_a) begin
      side_b_next.value = prod_a[FRAC_BITS +: WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_a;
    end
    out_side <= side_b_next;
    out_dvsr <= dvsr_a;
    out_dvnd <= dvnd_a;
  end

endmodule

/* hw/rtl/fpa_div_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div_step
// one registered restoring-division step, one quotient bit
// ----------------------------------------------------------------------------
module fpa_div_step import fpa_pkg::*; #(
  parameter int DW = WORD_W + FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [WORD_W-1:0] in_rem,
  input  logic [WORD_W-1:0] in_dvsr,
  input  logic [DW-1:0]     in_quo,
  output logic              out_valid,
  output side_t             out_side,
  output logic [WORD_W-1:0] out_rem,
  output logic [WORD_W-1:0] out_dvsr,
  output logic [DW-1:0]     out_quo
);

  logic [WORD_W:0] trial;
  logic [WORD_W:0] diff;
  logic            fits;

  // quo shifts dividend bits out at the top and quotient bits in at the bottom
  assign trial = {in_rem, in_quo[DW-1]};
  assign diff  = trial - {1'b0, in_dvsr};
  assign fits  = (trial >= {1'b0, in_dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_side <= in_side;
    out_dvsr <= in_dvsr;
    out_rem  <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    out_quo  <= {in_quo[DW-2:0], fits};
  end

endmodule

/* hw/rtl/fpa_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_divider
// unsigned divider pipeline, DW stages of one bit each
// ----------------------------------------------------------------------------
module fpa_divider import fpa_pkg::*; #(
  parameter int DW = WORD_W + FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [WORD_W-1:0] in_dvsr,
  input  logic [DW-1:0]     in_dvnd,
  output logic              out_valid,
  output side_t             out_side,
  output logic [DW-1:0]     out_quo
);

  logic              valid [DW+1];
  side_t             side  [DW+1];
  logic [WORD_W-1:0] rem   [DW+1];
  logic [WORD_W-1:0] dvsr  [DW+1];
  logic [DW-1:0]     quo   [DW+1];

  assign valid[0] = in_valid;
  assign side[0]  = in_side;
  assign rem[0]   = '0;
  assign dvsr[0]  = in_dvsr;
  assign quo[0]   = in_dvnd;

  for (genvar i = 0; i < DW; i++) begin : g_step
    fpa_div_step #(.DW(DW)) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_side   (side[i]),
      .in_rem    (rem[i]),
      .in_dvsr   (dvsr[i]),
      .in_quo    (quo[i]),
      .out_valid (valid[i+1]),
      .out_side  (side[i+1]),
      .out_rem   (rem[i+1]),
      .out_dvsr  (dvsr[i+1]),
      .out_quo   (quo[i+1])
    );
  end

  assign out_valid = valid[DW];
  assign out_side  = side[DW];
  assign out_quo   = quo[DW];

endmodule

/* hw/rtl/fixed_point_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// signed 32-bit fixed-point alu, fully pipelined, unless busy one op per cycle
// ----------------------------------------------------------------------------
// Usage: drive func, operand_a and operand_b with start high; the item is
// taken on any clock edge where busy is low. busy is high only around reset,
// so in normal use one item goes in every cycle. Every operation has the same
// latency, since each passes the same registers in this order:
// two front-end stages (decode and 32x32 multiply, then product scaling),
// 32 + FRAC_BITS divider stages that each resolve one quotient bit, and one
// output register. The latency is set by the one-bit-per-stage divider, and
// results of all other operations ride along it so that order is kept.
// Each result shows for exactly one cycle with done high; the receiver cannot
// stall the block, so it must take every transfer in the cycle it appears.
// ----------------------------------------------------------------------------
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [3:0]               func,
  input  logic signed [WORD_W-1:0] operand_a,
  input  logic signed [WORD_W-1:0] operand_b,
  output logic                     done,
  output logic signed [WORD_W-1:0] result_value,
  output logic                     compare_true,
  output logic                     divide_by_zero
);

  // scaled dividend width: |a| shifted up by the fraction bits
  localparam int DW = WORD_W + FRAC_BITS;

  logic              accept;
  logic              fe_valid;
  side_t             fe_side;
  logic [WORD_W-1:0] fe_dvsr;
  logic [DW-1:0]     fe_dvnd;
  logic              dv_valid;
  side_t             dv_side;
  logic [DW-1:0]     dv_quo;
  logic [WORD_W-1:0] quo_low;

  // busy is held through reset and the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start & ~busy;

  // decode, simple ops, multiply, divide operand magnitudes
  fpa_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .func      (func),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (fe_valid),
    .out_side  (fe_side),
    .out_dvsr  (fe_dvsr),
    .out_dvnd  (fe_dvnd)
  );

  // magnitude division, all other results carried in step
  fpa_divider #(.DW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_side   (fe_side),
    .in_dvsr   (fe_dvsr),
    .in_dvnd   (fe_dvnd),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo   (dv_quo)
  );

  // only the low word of the quotient survives; sign applied to that word
  assign quo_low = dv_quo[WORD_W-1:0];

  // output register: pick quotient or carried result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    compare_true   <= dv_side.cmp;
    divide_by_zero <= dv_side.is_div & dv_side.dz;
    if (!dv_side.is_div) begin
      result_value <= dv_side.value;
    end else if (dv_side.dz) begin
      result_value <= '0;
    end else if (dv_side.neg) begin
      result_value <= WORD_W'(-quo_low);
    end else begin
      result_value <= quo_low;
    end
  end

endmodule
